### src/arwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_pkg
// Shared types and constants of the anti-replay window checker.
// ----------------------------------------------------------------------------
package arwc_pkg;

	localparam int SEQ_W  = 32;
	localparam int CNT_W  = 32;
	localparam int QUAL_W = 7;
	localparam int QUO_W  = 7;
	// counter times 100 fits in CNT_W + 7 bits
	localparam int DIVD_W = CNT_W + QUAL_W;
	localparam int DIVS_W = CNT_W + 1;
	localparam int STEP_W = $clog2(QUO_W);

	localparam logic [QUAL_W-1:0] QUAL_SCALE = QUAL_W'(100);
	localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

	localparam logic STATUS_ACCEPT = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// one classified item handed from the front to the back
	typedef struct packed {
		logic             status;
		logic [CNT_W-1:0] acc;
		logic [CNT_W-1:0] rej;
	} arwc_entry_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} arwc_back_state_t;

endpackage

### src/arwc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_front
// Window check and saturating accept/reject counters; one item per cycle.
// ----------------------------------------------------------------------------
module arwc_front import arwc_pkg::*; #(
	parameter int WINDOW_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [SEQ_W-1:0] seq,
	output arwc_entry_t      entry
);

	localparam int SW = $clog2(WINDOW_BITS);

	logic                   started_q;
	logic [SEQ_W-1:0]       highest_q;
	logic [WINDOW_BITS-1:0] bitmap_q;
	logic [CNT_W-1:0]       acc_q;
	logic [CNT_W-1:0]       rej_q;

	logic                   started_n;
	logic [SEQ_W-1:0]       highest_n;
	logic [WINDOW_BITS-1:0] bitmap_n;
	logic [CNT_W-1:0]       acc_n;
	logic [CNT_W-1:0]       rej_n;
	logic [SEQ_W-1:0]       ahead;
	logic [SEQ_W-1:0]       behind;
	logic                   ok;

	assign ahead  = seq - highest_q;
	assign behind = highest_q - seq;

	always_comb begin
		started_n = started_q;
		highest_n = highest_q;
		bitmap_n  = bitmap_q;
		ok        = 1'b0;
		if (!started_q) begin
			started_n = 1'b1;
			highest_n = seq;
			bitmap_n  = WINDOW_BITS'(1);
			ok        = 1'b1;
		end else if (ahead != '0 && !ahead[SEQ_W-1]) begin
			// newer: slide the window forward
			if (ahead >= SEQ_W'(WINDOW_BITS)) begin
				bitmap_n = WINDOW_BITS'(1);
			end else begin
				bitmap_n = (bitmap_q << ahead[SW-1:0]) | WINDOW_BITS'(1);
			end
			highest_n = seq;
			ok        = 1'b1;
		end else if (behind < SEQ_W'(WINDOW_BITS)) begin
			if (!bitmap_q[behind[SW-1:0]]) begin
				bitmap_n = bitmap_q | (WINDOW_BITS'(1) << behind[SW-1:0]);
				ok       = 1'b1;
			end
		end
	end

	always_comb begin
		acc_n = acc_q;
		rej_n = rej_q;
		if (ok) begin
			if (acc_q != CNT_MAX) acc_n = acc_q + CNT_W'(1);
		end else begin
			if (rej_q != CNT_MAX) rej_n = rej_q + CNT_W'(1);
		end
	end

	assign entry.status = ok ? STATUS_ACCEPT : STATUS_REJECT;
	assign entry.acc    = acc_n;
	assign entry.rej    = rej_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			highest_q <= '0;
			bitmap_q  <= '0;
			acc_q     <= '0;
			rej_q     <= '0;
		end else if (in_valid) begin
			started_q <= started_n;
			highest_q <= highest_n;
			bitmap_q  <= bitmap_n;
			acc_q     <= acc_n;
			rej_q     <= rej_n;
		end
	end

endmodule

### src/arwc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_queue
// Two-entry queue between the window check and the quality divider.
// ----------------------------------------------------------------------------
module arwc_queue import arwc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  arwc_entry_t wr_data,
	output logic        q_full,
	input  logic        rd,
	output arwc_entry_t rd_data,
	output logic        q_empty,
	output logic [1:0]  count
);

	arwc_entry_t mem_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign rd_data = mem_q[rptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr) wptr_q <= ~wptr_q;
			if (rd) rptr_q <= ~rptr_q;
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/arwc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_back
// Link quality divider (restoring, one quotient bit per cycle) and the
// result register.
// ----------------------------------------------------------------------------
module arwc_back import arwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  arwc_entry_t       entry,
	input  logic              entry_avail,
	output logic              entry_take,
	input  logic              pop,
	output logic              empty,
	output logic              status,
	output logic [QUAL_W-1:0] link_quality
);

	arwc_back_state_t  state_q, state_n;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVS_W-1:0] div_q;
	logic [STEP_W-1:0] k_q;
	logic [QUO_W-1:0]  quo_q;
	logic              status_q;
	logic              zero_q;
	logic              load;
	logic [DIVD_W:0]   trial;

	assign trial = {1'b0, rem_q} - ((DIVD_W + 1)'(div_q) << k_q);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			B_IDLE: if (entry_avail) state_n = B_DIV;
			B_DIV:  if (k_q == '0) state_n = B_DONE;
			B_DONE: begin
				if (pop) state_n = entry_avail ? B_DIV : B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_comb begin
		load  = 1'b0;
		empty = 1'b1;
		unique case (state_q)
			B_IDLE: load = entry_avail;
			B_DIV:  load = 1'b0;
			B_DONE: begin
				empty = 1'b0;
				load  = pop && entry_avail;
			end
			default: load = 1'b0;
		endcase
	end

	assign entry_take   = load;
	assign status       = status_q;
	assign link_quality = zero_q ? '0 : QUAL_W'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else         state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q    <= DIVD_W'(entry.acc) * DIVD_W'(QUAL_SCALE);
			div_q    <= DIVS_W'(entry.acc) + DIVS_W'(entry.rej);
			zero_q   <= (entry.acc == '0) && (entry.rej == '0);
			status_q <= entry.status;
			k_q      <= STEP_W'(QUO_W - 1);
			quo_q    <= '0;
		end else if (state_q == B_DIV) begin
			if (!trial[DIVD_W]) begin
				rem_q      <= trial[DIVD_W-1:0];
				quo_q[k_q] <= 1'b1;
			end
			k_q <= k_q - STEP_W'(1);
		end
	end

endmodule

### src/anti_replay_window_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anti_replay_window_checker_top
// Anti-replay sliding window check with link quality percentage.
// An accepted item passes the queue and the 7-step quotient loop before its result is shown.
// The divider takes a new item only once its last result is popped;
// the window check takes items every cycle until the two-entry queue fills.
// Reset: arst_n clears the window, counters, queue and divider state at once.
// ----------------------------------------------------------------------------
module anti_replay_window_checker_top import arwc_pkg::*; #(
	parameter int WINDOW_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [SEQ_W-1:0]  sequence_req,
	output logic              empty,
	input  logic              pop,
	output logic              status,
	output logic [QUAL_W-1:0] link_quality
);

	arwc_entry_t f_entry;
	arwc_entry_t q_entry;
	logic        accept;
	logic        q_full;
	logic        q_empty;
	logic        q_take;
	logic [1:0]  q_count;

	assign accept = push && !q_full;
	assign full   = q_full;

	arwc_front #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.seq      (sequence_req),
		.entry    (f_entry)
	);

	arwc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_data (f_entry),
		.q_full  (q_full),
		.rd      (q_take),
		.rd_data (q_entry),
		.q_empty (q_empty),
		.count   (q_count)
	);

	arwc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry        (q_entry),
		.entry_avail  (!q_empty),
		.entry_take   (q_take),
		.pop          (pop),
		.empty        (empty),
		.status       (status),
		.link_quality (link_quality)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count != 2'd3)
		else $error("queue count out of range");

	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> !q_empty)
		else $error("divider took from an empty queue");

	a_quality_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> link_quality <= QUAL_W'(100))
		else $error("link quality above 100");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !q_take) |=> q_count == $past(q_count) + 2'd1)
		else $error("queue count did not follow a write");

endmodule

### tb/replay_verdict_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replay_verdict_monitor
// Watches the sequence and verdict channels of the anti-replay window checker,
// predicts each verdict from its own copy of the window and counters, and
// compares every popped verdict against the oldest predicted one.
// ----------------------------------------------------------------------------
module replay_verdict_monitor import arwc_pkg::*; #(
	parameter int WINDOW_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [SEQ_W-1:0]  sequence_req,
	input  logic              empty,
	input  logic              pop,
	input  logic              status,
	input  logic [QUAL_W-1:0] link_quality,
	output int                mismatch_count,
	output int                verdicts_pending
);

	typedef struct packed {
		logic              status;
		logic [QUAL_W-1:0] link_quality;
	} packet_verdict_t;

	packet_verdict_t predicted_verdicts [$];

	logic             win_open;
	logic [SEQ_W-1:0] newest_seq;
	logic [63:0]      seen_mask;
	logic [CNT_W-1:0] pass_cnt;
	logic [CNT_W-1:0] drop_cnt;
	int               verdicts_checked;

	function automatic logic [63:0] window_span_mask();
		if (WINDOW_BITS >= 64)
			return '1;
		return (64'd1 << WINDOW_BITS) - 64'd1;
	endfunction

	// window update plus counters and quality for one sequence
	task automatic screen_sequence(input logic [SEQ_W-1:0] seq, output packet_verdict_t v);
		logic [SEQ_W-1:0] ahead;
		logic [SEQ_W-1:0] back;
		logic             ok;
		logic [63:0]      num;
		logic [63:0]      den;
		ahead = seq - newest_seq;
		back  = newest_seq - seq;
		if (!win_open) begin
			win_open   = 1'b1;
			newest_seq = seq;
			seen_mask  = 64'd1;
			ok = 1'b1;
		end else if (ahead != '0 && !ahead[SEQ_W-1]) begin
			if (ahead >= SEQ_W'(WINDOW_BITS) || ahead >= SEQ_W'(64))
				seen_mask = '0;
			else
				seen_mask = (seen_mask << ahead) & window_span_mask();
			seen_mask[0] = 1'b1;
			newest_seq = seq;
			ok = 1'b1;
		end else if (back >= SEQ_W'(WINDOW_BITS) || back >= SEQ_W'(64)) begin
			ok = 1'b0;
		end else if (seen_mask[back[5:0]]) begin
			ok = 1'b0;
		end else begin
			seen_mask[back[5:0]] = 1'b1;
			seen_mask = seen_mask & window_span_mask();
			ok = 1'b1;
		end

		if (ok) begin
			if (pass_cnt != CNT_MAX)
				pass_cnt = pass_cnt + CNT_W'(1);
		end else begin
			if (drop_cnt != CNT_MAX)
				drop_cnt = drop_cnt + CNT_W'(1);
		end

		num = 64'(pass_cnt) * 64'd100;
		den = 64'(pass_cnt) + 64'(drop_cnt);
		v.status = ok ? STATUS_ACCEPT : STATUS_REJECT;
		v.link_quality = (den == 64'd0) ? '0 : QUAL_W'(num / den);
	endtask

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("[%0t] verdict %0d: %s expected %0d got %0d",
			$realtime, verdicts_checked, what, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		packet_verdict_t want;
		packet_verdict_t fresh;
		if (!arst_n) begin
			win_open         = 1'b0;
			newest_seq       = '0;
			seen_mask        = '0;
			pass_cnt         = '0;
			drop_cnt         = '0;
			mismatch_count   = 0;
			verdicts_pending = 0;
			verdicts_checked = 0;
			predicted_verdicts.delete();
		end else begin
			if (pop && !empty) begin
				if (predicted_verdicts.size() == 0) begin
					report_mismatch("unexpected item, status", 0, status);
				end else begin
					want = predicted_verdicts.pop_front();
					if (status !== want.status)
						report_mismatch("status", want.status, status);
					if (link_quality !== want.link_quality)
						report_mismatch("link_quality", want.link_quality, link_quality);
				end
				verdicts_checked++;
			end
			if (push && !full) begin
				screen_sequence(sequence_req, fresh);
				predicted_verdicts.push_back(fresh);
			end
			verdicts_pending = predicted_verdicts.size();
		end
	end

endmodule

### tb/anti_replay_window_checker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anti_replay_window_checker_top_test
// Drives sequence numbers into the anti-replay window checker: a directed
// pass over window edges, wraparound and half-range distance, then random
// in-order, late, replayed and far-off sequences with bursty stalls on both
// channels. Verdicts are checked by replay_verdict_monitor.
// ----------------------------------------------------------------------------
module anti_replay_window_checker_top_test;
	import arwc_pkg::*;

	localparam int RANDOM_ITEMS = 1100;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [SEQ_W-1:0]  sequence_req;
	logic              empty;
	logic              pop;
	logic              status;
	logic [QUAL_W-1:0] link_quality;
	int                mismatch_count;
	int                verdicts_pending;
	logic              calm;

	// window edges, 32-bit wrap and the half-range distance
	logic [SEQ_W-1:0] opening_seqs [19] = '{
		32'hFFFF_FFC0, 32'hFFFF_FFC0, 32'hFFFF_FFBF, 32'hFFFF_FF81, 32'hFFFF_FF80,
		32'hFFFF_FF81, 32'hFFFF_FFFF, 32'hFFFF_FFC0, 32'h0000_0000, 32'hFFFF_FFC1,
		32'h0000_0040, 32'h0000_0001, 32'h8000_0040, 32'h8000_003F, 32'h0000_0040,
		32'h8000_003F, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001
	};

	anti_replay_window_checker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sequence_req (sequence_req),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.link_quality (link_quality)
	);

	replay_verdict_monitor verdict_monitor (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.sequence_req     (sequence_req),
		.empty            (empty),
		.pop              (pop),
		.status           (status),
		.link_quality     (link_quality),
		.mismatch_count   (mismatch_count),
		.verdicts_pending (verdicts_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("anti_replay_window_checker_top verification failed");
		$finish;
	end

	task automatic send_item(input logic [SEQ_W-1:0] seq);
		push         <= 1'b1;
		sequence_req <= seq;
		do @(posedge clk); while (full);
		if (!calm && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// result side: pop mostly high, dropped in short bursts
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [SEQ_W-1:0] newest;
		logic [SEQ_W-1:0] offset;
		logic [SEQ_W-1:0] seq;
		int               pick;
		arst_n       = 1'b0;
		push         = 1'b0;
		sequence_req = '0;
		calm         = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_seqs[i])
			send_item(opening_seqs[i]);

		// newest accepted sequence after the directed pass
		newest = 32'h8000_003F;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 400 && n < 500) || n >= RANDOM_ITEMS - 100;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				seq = newest + SEQ_W'($urandom_range(1, 4));
				newest = seq;
			end else if (pick < 40) begin
				seq = newest + SEQ_W'($urandom_range(5, 70));
				newest = seq;
			end else if (pick < 70) begin
				seq = newest - SEQ_W'($urandom_range(0, 70));
			end else if (pick < 80) begin
				seq = newest - SEQ_W'($urandom_range(0, 3));
			end else if (pick < 90) begin
				offset = $urandom;
				seq = newest + offset;
				if (offset != '0 && !offset[SEQ_W-1])
					newest = seq;
			end else if (pick < 95) begin
				if ($urandom_range(0, 1) == 0) begin
					seq = newest + 32'h8000_0000;
				end else begin
					seq = newest + 32'h7FFF_FFFF - SEQ_W'($urandom_range(0, 3));
					newest = seq;
				end
			end else begin
				seq = newest + SEQ_W'($urandom_range(63, 65));
				newest = seq;
			end
			send_item(seq);
		end
		push <= 1'b0;

		while (verdicts_pending != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		if (mismatch_count == 0)
			$display("anti_replay_window_checker_top verification clean");
		else
			$display("anti_replay_window_checker_top verification failed");
		$finish;
	end

endmodule

### filelist.f
src/arwc_pkg.sv
src/arwc_front.sv
src/arwc_queue.sv
src/arwc_back.sv
src/anti_replay_window_checker_top.sv
tb/replay_verdict_monitor.sv
tb/anti_replay_window_checker_top_test.sv
